@@ design/twrd_pkg.sv @@
// Shared types and constants for the template window RGB distance core.
// Used by twrd_ctrl, twrd_dp and template_window_rgb_distance_core.
package twrd_pkg;

    localparam int TOTAL_W     = 40;
    localparam int COORD_W     = 13;
    localparam int SIDE_W      = 11;
    localparam int IMG_W       = 13;
    localparam int PEN_W       = 24;
    localparam int DIST_W      = 10;
    localparam int COLOR_W     = 8;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam int MAX_TEMPLATE_SIDE = 1024;
    localparam int MAX_IMAGE_SIDE    = 4096;

    localparam int SQ_W        = 18;
    localparam int ROOT_W      = 9;
    localparam int REM_W       = 10;
    localparam int ROOT_STEPS  = 9;
    localparam int STEP_W      = 4;

    localparam logic [IMG_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [IMG_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [PEN_W-1:0]  RST_EDGE_PENALTY = 24'd0;
    localparam logic [DIST_W-1:0] RST_MAX_DIST     = 10'd441;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_PENALTY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST     = 2'd3;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [1:0] SIDE_RIGHT  = 2'd0;
    localparam logic [1:0] SIDE_LEFT   = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_TOP    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEN,
        ST_PEN_DRAIN,
        ST_SQ,
        ST_ROOT,
        ST_ROOT_ADD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       load_win;
        logic       load_pix;
        logic       clr_acc;
        logic       pen_en;
        logic [1:0] side;
        logic       sq_en;
        logic       root_step;
        logic       root_add;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

@@ design/twrd_ctrl.sv @@
// Sequencer for the template window RGB distance core.
// Depends on twrd_pkg; drives twrd_dp through t_dp_cmd.
module twrd_ctrl
    import twrd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_command,
    input  logic     i_in_last,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state              r_state, n_state;
    logic [1:0]          r_side, n_side;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_side  <= '0;
            r_step  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
            r_step  <= n_step;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_side  = '0;
        n_step  = '0;
        n_last  = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_last  = i_in_last;
                    n_state = (i_in_command == CMD_START) ? ST_PEN : ST_SQ;
                end
            end
            ST_PEN: begin
                n_side = r_side + 2'd1;
                if (r_side == SIDE_TOP) begin
                    n_state = ST_PEN_DRAIN;
                end
            end
            ST_PEN_DRAIN: begin
                n_state = r_last ? ST_EMIT : ST_IDLE;
            end
            ST_SQ: begin
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                    n_state = ST_ROOT_ADD;
                end
            end
            ST_ROOT_ADD: begin
                n_state = r_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_cmd           = '0;
        o_cmd.side      = r_side;
        o_cmd.load_win  = o_in_ready && i_in_valid && (i_in_command == CMD_START);
        o_cmd.clr_acc   = o_cmd.load_win;
        o_cmd.load_pix  = o_in_ready && i_in_valid && (i_in_command == CMD_PIXEL);
        o_cmd.pen_en    = (r_state == ST_PEN);
        o_cmd.sq_en     = (r_state == ST_SQ);
        o_cmd.root_step = (r_state == ST_ROOT);
        o_cmd.root_add  = (r_state == ST_ROOT_ADD);
        o_cmd.emit      = (r_state == ST_EMIT) && i_stat.out_free;
    end

endmodule

@@ design/twrd_dp.sv @@
// Datapath: config registers, clip penalty pipeline, RGB distance with
// iterative square root, saturating total and output register. Uses twrd_pkg.
module twrd_dp
    import twrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IN_DATA_W-1:0]  i_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [TOTAL_W-1:0]    o_window_distance,
    output logic                  o_off_image
);

    localparam int EXT_W  = COORD_W + 2;
    localparam int P1_W   = 2 * SIDE_W;
    localparam int P2_W   = P1_W + DIST_W + 1;

    logic [IMG_W-1:0]  r_img_w, r_img_h;
    logic [PEN_W-1:0]  r_edge_pen;
    logic [DIST_W-1:0] r_max_dist;

    logic signed [COORD_W-1:0] r_x, r_y;
    logic [SIDE_W-1:0]         r_w, r_h;
    logic [COLOR_W-1:0]        r_ir, r_ig, r_ib, r_tr, r_tg, r_tb;

    logic [P1_W-1:0]   r_prod1;
    logic              r_hit;
    logic              r_pen_vld;

    logic [SQ_W-1:0]   r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_flag, n_flag;
    logic               r_out_vld;
    logic [TOTAL_W-1:0] r_out_dist;
    logic               r_out_flag;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w    <= RST_IMAGE_WIDTH;
            r_img_h    <= RST_IMAGE_HEIGHT;
            r_edge_pen <= RST_EDGE_PENALTY;
            r_max_dist <= RST_MAX_DIST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_img_w    <= i_cfg_data[IMG_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h    <= i_cfg_data[IMG_W-1:0];
                CFG_EDGE_PENALTY: r_edge_pen <= i_cfg_data[PEN_W-1:0];
                CFG_MAX_DIST:     r_max_dist <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // input capture
    logic [SIDE_W-1:0] in_w, in_h;
    assign in_w = i_data[36:26];
    assign in_h = i_data[47:37];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_win) begin
            r_x <= i_data[12:0];
            r_y <= i_data[25:13];
            r_w <= (in_w > SIDE_W'(MAX_TEMPLATE_SIDE)) ? SIDE_W'(MAX_TEMPLATE_SIDE) : in_w;
            r_h <= (in_h > SIDE_W'(MAX_TEMPLATE_SIDE)) ? SIDE_W'(MAX_TEMPLATE_SIDE) : in_h;
        end
        if (i_cmd.load_pix) begin
            r_ir <= i_data[55:48];
            r_ig <= i_data[63:56];
            r_ib <= i_data[71:64];
            r_tr <= i_data[79:72];
            r_tg <= i_data[87:80];
            r_tb <= i_data[95:88];
        end
    end

    // clip penalty, stage 1: clipped count times span
    logic                      horiz, near;
    logic signed [COORD_W-1:0] pos;
    logic [SIDE_W-1:0]         len, span;
    logic [IMG_W-1:0]          lim_raw, lim;
    logic signed [EXT_W-1:0]   pos_x, len_x, lim_x, end_x, ov_x, neg_x, cnt_x;
    logic                      hit;
    logic [SIDE_W-1:0]         cnt;

    always_comb begin
        horiz   = (i_cmd.side == SIDE_RIGHT) || (i_cmd.side == SIDE_LEFT);
        near    = (i_cmd.side == SIDE_LEFT) || (i_cmd.side == SIDE_TOP);
        pos     = horiz ? r_x : r_y;
        len     = horiz ? r_w : r_h;
        span    = horiz ? r_h : r_w;
        lim_raw = horiz ? r_img_w : r_img_h;
        lim     = (lim_raw > IMG_W'(MAX_IMAGE_SIDE)) ? IMG_W'(MAX_IMAGE_SIDE) : lim_raw;
        pos_x   = EXT_W'(pos);
        len_x   = $signed({{(EXT_W-SIDE_W){1'b0}}, len});
        lim_x   = $signed({{(EXT_W-IMG_W){1'b0}}, lim});
        end_x   = pos_x + len_x;
        ov_x    = end_x - lim_x;
        neg_x   = -pos_x;
        if (near) begin
            hit   = (pos_x < 0);
            cnt_x = neg_x;
        end else begin
            hit   = (end_x > lim_x);
            cnt_x = ov_x;
        end
        cnt = (cnt_x > len_x) ? len : cnt_x[SIDE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_vld <= 1'b0;
        end else begin
            r_pen_vld <= i_cmd.pen_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pen_en) begin
            r_hit   <= hit;
            r_prod1 <= hit ? (P1_W'(cnt) * P1_W'(span)) : '0;
        end
    end

    // clip penalty, stage 2 term
    logic [P2_W-1:0] pen_term;
    assign pen_term = P2_W'(r_prod1) * P2_W'(r_max_dist) + P2_W'(r_edge_pen);

    // squared RGB distance
    logic [COLOR_W-1:0] dr, dg, db;
    logic [SQ_W-1:0]    sq_sum;

    always_comb begin
        dr     = (r_ir > r_tr) ? r_ir - r_tr : r_tr - r_ir;
        dg     = (r_ig > r_tg) ? r_ig - r_tg : r_tg - r_ig;
        db     = (r_ib > r_tb) ? r_ib - r_tb : r_tb - r_ib;
        sq_sum = SQ_W'(dr) * SQ_W'(dr) + SQ_W'(dg) * SQ_W'(dg) + SQ_W'(db) * SQ_W'(db);
    end

    // integer square root, two radicand bits per step
    logic [REM_W+1:0] rem_sh, trial;
    logic             fits;

    always_comb begin
        rem_sh = {r_rem, r_rad[SQ_W-1:SQ_W-2]};
        trial  = (REM_W+2)'({r_root, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_en) begin
            r_rad  <= sq_sum;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
            r_rem  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    // running total
    logic [TOTAL_W:0]   add_sum;
    logic [TOTAL_W-1:0] add_in;

    always_comb begin
        add_in  = i_cmd.root_add ? TOTAL_W'(r_root) : TOTAL_W'(pen_term);
        add_sum = {1'b0, r_total} + {1'b0, add_in};
        n_total = r_total;
        n_flag  = r_flag;
        if (i_cmd.clr_acc || i_cmd.emit) begin
            n_total = '0;
            n_flag  = 1'b0;
        end else if ((r_pen_vld && r_hit) || i_cmd.root_add) begin
            n_total = add_sum[TOTAL_W] ? '1 : add_sum[TOTAL_W-1:0];
            n_flag  = r_flag || r_pen_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_total <= n_total;
            r_flag  <= n_flag;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_dist <= r_total;
            r_out_flag <= r_flag;
        end
    end

    assign o_stat.out_free    = !r_out_vld || i_out_ready;
    assign o_out_valid        = r_out_vld;
    assign o_window_distance  = r_out_dist;
    assign o_off_image        = r_out_flag;

endmodule

@@ design/template_window_rgb_distance_core.sv @@
// Top level of the template window RGB distance core.
// Instantiates twrd_ctrl and twrd_dp; types and constants from twrd_pkg.
//
// Scores one placement of a template over an image. A start item (tuser 0)
// clears the total and charges each clipped side with clipped count times
// the other window side times the per-pixel distance ceiling, plus edge_penalty;
// it is accepted, then four sides pass a two-stage multiply, then one drain.
// A pixel-pair item (tuser 1) adds floor(sqrt(dr^2+dg^2+db^2)) to a total
// that saturates at 2^40-1; it runs through the square root unit, which
// resolves one result bit per cycle. An item with tlast set then loads
// the output register, waiting while a previous result is held and not taken;
// then the total and the clipped flag return to zero. One item is in
// work at a time; a finished result waits in the output register while
// the next item is taken. Config writes are accepted at any cycle and
// must be issued only while the core is idle.
module template_window_rgb_distance_core
    import twrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // win_x[12:0], win_y[25:13], win_width[36:26], win_height[47:37],
    // img_red[55:48], img_green[63:56], img_blue[71:64],
    // tpl_red[79:72], tpl_green[87:80], tpl_blue[95:88]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command[0]
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // window_distance[39:0]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // off_image[0]
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    twrd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_command (s_axis_tuser),
        .i_in_last    (s_axis_tlast),
        .o_in_ready   (s_axis_tready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    twrd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_data            (s_axis_tdata),
        .o_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .o_window_distance (m_axis_tdata),
        .o_off_image       (m_axis_tuser)
    );

endmodule

@@ test/tb_top.sv @@
// Testbench for template_window_rgb_distance_core: streams window starts and pixel pairs,
// predicts each window score in-bench and checks every result item against it.
// Depends on twrd_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;
    import twrd_pkg::*;

    localparam int                  SETTLE_CYCLES = 24;
    localparam int                  CYCLE_LIMIT   = 400000;
    localparam int                  RANDOM_ITEMS  = 750;
    localparam longint unsigned     TOTAL_CAP     = (64'd1 << TOTAL_W) - 1;

    typedef struct {
        logic               cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIDE_W-1:0]  w;
        logic [SIDE_W-1:0]  h;
        logic [COLOR_W-1:0] ir, ig, ib;
        logic [COLOR_W-1:0] tr, tg, tb;
        logic               last;
    } t_win_item;

    typedef struct {
        logic [TOTAL_W-1:0] total;
        logic               off;
    } t_score;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata   = '0;
    logic                  s_axis_tuser   = 1'b0;
    logic                  s_axis_tlast   = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    template_window_rgb_distance_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // shadow registers and window state
    logic [IMG_W-1:0]  reg_img_w    = RST_IMAGE_WIDTH;
    logic [IMG_W-1:0]  reg_img_h    = RST_IMAGE_HEIGHT;
    logic [PEN_W-1:0]  reg_edge_pen = RST_EDGE_PENALTY;
    logic [DIST_W-1:0] reg_max_dist = RST_MAX_DIST;
    longint unsigned   score_total  = 0;
    logic              score_clipped = 1'b0;

    t_score expected_scores[$];
    int     err_count   = 0;
    int     items_sent  = 0;
    int     burst_left  = 0;
    bit     gaps_on     = 1'b1;
    int     cycle_count = 0;

    int     rx_cycle = 0;
    int     rx_mode  = 0;
    int     rx_hold  = 0;

    // ---------------- predictor ----------------
    function automatic int unsigned floor_root(int unsigned v);
        int unsigned r;
        int unsigned t;
        r = 0;
        for (int b = 9; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    task automatic add_to_total(longint unsigned v);
        longint unsigned s;
        s = score_total + v;
        score_total = (s > TOTAL_CAP) ? TOTAL_CAP : s;
    endtask

    task automatic charge_side(longint clip, longint side, longint span);
        longint c;
        c = (clip > side) ? side : clip;
        add_to_total(c * span * longint'(reg_max_dist) + longint'(reg_edge_pen));
        score_clipped = 1'b1;
    endtask

    task automatic predict_score(t_win_item it);
        longint x, y, w, h, iw, ih;
        int     dr, dg, db;
        t_score s;
        if (it.cmd == CMD_START) begin
            x  = longint'($signed(it.x));
            y  = longint'($signed(it.y));
            w  = (it.w > MAX_TEMPLATE_SIDE) ? MAX_TEMPLATE_SIDE : it.w;
            h  = (it.h > MAX_TEMPLATE_SIDE) ? MAX_TEMPLATE_SIDE : it.h;
            iw = (reg_img_w > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : reg_img_w;
            ih = (reg_img_h > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : reg_img_h;
            score_total   = 0;
            score_clipped = 1'b0;
            if (x + w > iw) charge_side(x + w - iw, w, h);
            if (x < 0)      charge_side(-x, w, h);
            if (y + h > ih) charge_side(y + h - ih, h, w);
            if (y < 0)      charge_side(-y, h, w);
        end else begin
            dr = int'(it.ir) - int'(it.tr);
            dg = int'(it.ig) - int'(it.tg);
            db = int'(it.ib) - int'(it.tb);
            add_to_total(floor_root(dr * dr + dg * dg + db * db));
        end
        if (it.last) begin
            s.total = score_total[TOTAL_W-1:0];
            s.off   = score_clipped;
            expected_scores.push_back(s);
            score_total   = 0;
            score_clipped = 1'b0;
        end
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] %s: got %0h expected %0h", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_score want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_scores.size() == 0) begin
                report_mismatch("unexpected result item", m_axis_tdata, 0);
            end else begin
                want = expected_scores.pop_front();
                if (m_axis_tdata !== want.total)
                    report_mismatch("window_distance", m_axis_tdata, want.total);
                if (m_axis_tuser !== want.off)
                    report_mismatch("off_image", m_axis_tuser, want.off);
            end
        end
    end

    // receiver stall pattern: always ready, coin toss, or long stalls
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 200 == 0) rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_hold != 0) begin
                    rx_hold       <= rx_hold - 1;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    rx_hold       <= $urandom_range(0, 1) ? $urandom_range(5, 40) : 0;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------- drivers ----------------
    task automatic send_item(t_win_item it);
        int gap;
        if (burst_left == 0) begin
            if (gaps_on) begin
                gap = $urandom_range(1, 20);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tlast  <= it.last;
        s_axis_tdata  <= {it.tb, it.tg, it.tr, it.ib, it.ig, it.ir, it.h, it.w, it.y, it.x};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_score(it);
        items_sent++;
    endtask

    task automatic wait_scores_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        logic [CFG_DATA_W-1:0] noisy;
        noisy = CFG_DATA_W'($urandom);
        case (idx)
            CFG_IMAGE_WIDTH:  noisy = {noisy[CFG_DATA_W-1:IMG_W], val[IMG_W-1:0]};
            CFG_IMAGE_HEIGHT: noisy = {noisy[CFG_DATA_W-1:IMG_W], val[IMG_W-1:0]};
            CFG_EDGE_PENALTY: noisy = val[PEN_W-1:0];
            default:          noisy = {noisy[CFG_DATA_W-1:DIST_W], val[DIST_W-1:0]};
        endcase
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= noisy;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH:  reg_img_w    = noisy[IMG_W-1:0];
            CFG_IMAGE_HEIGHT: reg_img_h    = noisy[IMG_W-1:0];
            CFG_EDGE_PENALTY: reg_edge_pen = noisy[PEN_W-1:0];
            default:          reg_max_dist = noisy[DIST_W-1:0];
        endcase
    endtask

    task automatic program_regs(int unsigned iw, int unsigned ih, int unsigned pen,
                                int unsigned ceil_d);
        wait_scores_drained();
        write_reg(CFG_IMAGE_WIDTH, iw);
        write_reg(CFG_IMAGE_HEIGHT, ih);
        write_reg(CFG_EDGE_PENALTY, pen);
        write_reg(CFG_MAX_DIST, ceil_d);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------- item builders ----------------
    function automatic t_win_item random_item();
        t_win_item it;
        it.cmd  = 1'($urandom_range(0, 1));
        it.x    = COORD_W'($urandom);
        it.y    = COORD_W'($urandom);
        it.w    = SIDE_W'($urandom);
        it.h    = SIDE_W'($urandom);
        it.ir   = COLOR_W'($urandom);
        it.ig   = COLOR_W'($urandom);
        it.ib   = COLOR_W'($urandom);
        it.tr   = COLOR_W'($urandom);
        it.tg   = COLOR_W'($urandom);
        it.tb   = COLOR_W'($urandom);
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_win_item make_start(int x, int y, int w, int h, bit last);
        t_win_item it;
        it      = random_item();
        it.cmd  = CMD_START;
        it.x    = COORD_W'(x);
        it.y    = COORD_W'(y);
        it.w    = SIDE_W'(w);
        it.h    = SIDE_W'(h);
        it.last = last;
        return it;
    endfunction

    function automatic t_win_item make_pair(int ir, int ig, int ib, int tr, int tg, int tb,
                                            bit last);
        t_win_item it;
        it      = random_item();
        it.cmd  = CMD_PIXEL;
        {it.ir, it.ig, it.ib} = {8'(ir), 8'(ig), 8'(ib)};
        {it.tr, it.tg, it.tb} = {8'(tr), 8'(tg), 8'(tb)};
        it.last = last;
        return it;
    endfunction

    function automatic int pick_side();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 2047);
            1:       return MAX_TEMPLATE_SIDE;
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    function automatic int pick_coord(int img, int side);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 8191);
            1:       return -$urandom_range(1, 30);
            2:       return img - side + $urandom_range(0, 30) - 15;
            default: return $urandom_range(0, img);
        endcase
    endfunction

    task automatic send_window(int n_pairs, bit close);
        t_win_item it;
        int        w, h, iw, ih;
        iw = (reg_img_w > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : reg_img_w;
        ih = (reg_img_h > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : reg_img_h;
        w  = pick_side();
        h  = pick_side();
        send_item(make_start(pick_coord(iw, w), pick_coord(ih, h), w, h,
                             close && n_pairs == 0));
        for (int i = 0; i < n_pairs; i++) begin
            it      = random_item();
            it.cmd  = CMD_PIXEL;
            it.last = close && (i == n_pairs - 1);
            if ($urandom_range(0, 7) == 0)
                {it.ir, it.ig, it.ib, it.tr, it.tg, it.tb} = $urandom_range(0, 1) ?
                    {24'hFFFFFF, 24'h0} : {24'h0, 24'hFFFFFF};
            send_item(it);
        end
    endtask

    task automatic run_windows(int n_items);
        int target;
        int k;
        target = items_sent + n_items;
        while (items_sent < target) begin
            k = $urandom_range(0, 9);
            if (k < 8)       send_window($urandom_range(0, 12), 1'b1);
            else if (k == 8) send_window($urandom_range(0, 6), 1'b0);
            else             send_item(random_item());
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_directed_edges();
        // reset register values
        send_item(make_start(0, 0, 1, 1, 1'b1));
        send_item(make_start(0, 0, 4, 1, 1'b0));
        send_item(make_pair(255, 255, 255, 0, 0, 0, 1'b0));
        send_item(make_pair(0, 0, 0, 255, 255, 255, 1'b0));
        send_item(make_pair(17, 99, 200, 17, 99, 200, 1'b0));
        send_item(make_pair(3, 4, 0, 0, 0, 0, 1'b1));
        // clipped beyond window, oversize sides, left and top, then right and bottom
        send_item(make_start(-4096, -4096, 2047, 2047, 1'b1));
        send_item(make_start(4095, 4095, 1024, 1024, 1'b1));
        // corners counted twice
        send_item(make_start(-10, -10, 1024, 1024, 1'b1));
        send_item(make_start(0, 0, 0, 0, 1'b1));
        send_item(make_start(639, 479, 1, 1, 1'b1));
        send_item(make_start(640, 480, 1, 1, 1'b1));
        // pairs with no start after a result
        send_item(make_pair(1, 2, 3, 4, 6, 3, 1'b0));
        send_item(make_pair(0, 255, 0, 255, 0, 255, 1'b1));
        // restart before close
        send_item(make_start(-1, 5, 8, 8, 1'b0));
        send_item(make_pair(10, 20, 30, 40, 50, 60, 1'b0));
        send_item(make_start(3, 5, 8, 8, 1'b0));
        send_item(make_pair(200, 10, 90, 5, 250, 90, 1'b1));
        send_item(make_pair(128, 128, 128, 127, 127, 127, 1'b1));
    endtask

    task automatic test_register_extremes();
        program_regs(1, 1, 24'hFFFFFF, 1023);
        send_item(make_start(-4096, 4095, 2047, 1024, 1'b1));
        run_windows(25);
        program_regs(4096, 4096, 0, 0);
        send_item(make_start(-4096, -4096, 1024, 1024, 1'b1));
        run_windows(25);
        program_regs(8191, 8191, 123456, 1023);
        run_windows(25);
        program_regs(0, 0, 1, 1);
        run_windows(25);
        program_regs(16, 4096, 24'hFFFFFF, 441);
        run_windows(25);
    endtask

    task automatic test_random_windows();
        for (int phase = 0; phase < 3; phase++) begin
            program_regs($urandom_range(1, 700), $urandom_range(1, 700),
                         $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 1023));
            run_windows(RANDOM_ITEMS / 8);
            wait_scores_drained();
            run_windows(RANDOM_ITEMS / 8);
        end
    endtask

    task automatic finish_run();
        wait_scores_drained();
        if (err_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_register_extremes();
        test_random_windows();
        finish_run();
    end

endmodule

@@ files.f @@
design/twrd_pkg.sv
design/twrd_ctrl.sv
design/twrd_dp.sv
design/template_window_rgb_distance_core.sv
test/tb_top.sv
